// ===== src/potca_pkg.sv =====
package potca_pkg;

	localparam int SIZE_CLASSES = 32;
	localparam int STACK_DEPTH = 64;
	localparam int MAX_BLOCKS = 256;

	localparam int CW = $clog2(SIZE_CLASSES);
	localparam int SW = $clog2(STACK_DEPTH);
	localparam int BW = $clog2(MAX_BLOCKS);
	localparam int SAW = CW + SW;

	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE = 2'd1;
	localparam logic [1:0] ACT_RESIZE = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam logic [2:0] ERR_OK = 3'd0;
	localparam logic [2:0] ERR_UNKNOWN = 3'd1;
	localparam logic [2:0] ERR_EXHAUSTED = 3'd2;
	localparam logic [2:0] ERR_FULL = 3'd3;
	localparam logic [2:0] ERR_TOO_LARGE = 3'd4;

	localparam logic CFG_HEAP_BASE = 1'b0;
	localparam logic CFG_HEAP_LIMIT = 1'b1;

	typedef struct packed {
		logic [1:0] action;
		logic [31:0] block_address;
		logic [31:0] request_size;
	} req_t;

	typedef struct packed {
		logic [31:0] result_address;
		logic is_null;
		logic [2:0] error_code;
		logic copy_needed;
		logic [31:0] copy_source;
		logic [31:0] copy_length;
	} rsp_t;

	// Classified request handed from front to back.
	typedef struct packed {
		logic [1:0] action;
		logic [31:0] block_address;
		logic [31:0] request_size;
		logic size_zero;
		logic too_large;
		logic [5:0] size_class;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SEARCH,
		ST_SEARCH_WAIT,
		ST_FOUND,
		ST_RESIZE_CHK,
		ST_ALLOC,
		ST_POP_WAIT,
		ST_CARVE,
		ST_FREE,
		ST_DONE
	} state_t;

	// Smallest c with 2^c >= size, size in 1..2^31; 6 bits to hold 32, the result for larger sizes or zero.
	function automatic logic [5:0] ceil_log2(input logic [31:0] size);
		logic [31:0] m;
		logic [5:0] r;
		m = size - 32'd1;
		r = 6'd0;
		for (int i = 0; i < 32; i++) begin
			if (m[i]) r = 6'(i + 1);
		end
		return r;
	endfunction

endpackage

// ===== src/potca_ram.sv =====
module potca_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== src/potca_front.sv =====
module potca_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input potca_pkg::req_t req,
	output logic cmd_valid,
	input logic cmd_take,
	output potca_pkg::cmd_t cmd
);
	import potca_pkg::*;

	// Two-entry queue of classified requests.
	cmd_t q_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t c;
	logic [5:0] lg;

	assign lg = ceil_log2(req.request_size);
	always_comb begin
		c.action = req.action;
		c.block_address = req.block_address;
		c.request_size = req.request_size;
		c.size_zero = (req.request_size == 32'd0);
		c.too_large = (req.request_size > 32'h8000_0000) || (lg >= 6'(SIZE_CLASSES));
		c.size_class = lg;
	end

	assign full = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) q_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (cmd_take && cmd_valid) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(cmd_take && cmd_valid);
		end
	end
endmodule

// ===== src/potca_back.sv =====
module potca_back (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_sel,
	input logic [31:0] cfg_data,
	input logic cmd_valid,
	output logic cmd_take,
	input potca_pkg::cmd_t cmd,
	output logic rsp_valid,
	input logic rsp_take,
	output potca_pkg::rsp_t rsp
);
	import potca_pkg::*;

	state_t st_q, st_d;
	cmd_t cmd_q;
	logic [31:0] limit_q, bump_q;
	logic [SW:0] scnt_q [SIZE_CLASSES];
	logic [BW:0] bcnt_q;
	logic [BW:0] idx_q;
	logic [CW-1:0] oc_q;
	logic [2:0] err_q;
	logic [31:0] res_q;
	logic copy_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	// Memories.
	logic tw_we;
	logic [BW-1:0] tw_addr, tr_addr;
	logic [31+CW:0] tw_data, tr_data;
	logic sw_we;
	logic [SAW-1:0] sw_addr, sr_addr;
	logic [31:0] sw_data, sr_data;

	potca_ram #(.WIDTH(32 + CW), .DEPTH(MAX_BLOCKS)) u_table (
		.clk(clk), .we(tw_we), .waddr(tw_addr), .wdata(tw_data),
		.raddr(tr_addr), .rdata(tr_data)
	);
	potca_ram #(.WIDTH(32), .DEPTH(SIZE_CLASSES * STACK_DEPTH)) u_stack (
		.clk(clk), .we(sw_we), .waddr(sw_addr), .wdata(sw_data),
		.raddr(sr_addr), .rdata(sr_data)
	);

	logic [CW-1:0] nc;
	logic [32:0] start_w, end_w;
	logic [SW:0] ncnt, ocnt;
	logic [32:0] old_len;

	assign nc = cmd_q.size_class[CW-1:0];
	assign ncnt = scnt_q[nc];
	assign ocnt = scnt_q[oc_q];
	assign start_w = {1'b0, bump_q} + 33'd8 - {30'd0, bump_q[2:0]};
	assign end_w = start_w + (33'd1 << nc);
	assign old_len = 33'd1 << oc_q;

	assign tr_addr = idx_q[BW-1:0];
	assign sr_addr = {nc, SW'(ncnt - 1'b1)};
	assign tw_addr = bcnt_q[BW-1:0];
	assign tw_data = {start_w[31:0], nc};
	assign sw_addr = {oc_q, ocnt[SW-1:0]};
	assign sw_data = cmd_q.block_address;

	// Alloc path of a resize keeps the old block pending for the free.
	logic is_move;
	assign is_move = (cmd_q.action == ACT_RESIZE) && (cmd_q.block_address != 32'd0);

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (cmd_valid && !rsp_valid_q) st_d = ST_DISPATCH;
			ST_DISPATCH: begin
				case (cmd_q.action)
					ACT_ALLOC: st_d = ST_ALLOC;
					ACT_FREE: st_d = (cmd_q.block_address == 32'd0) ? ST_DONE : ST_SEARCH;
					ACT_RESIZE: st_d = (cmd_q.block_address == 32'd0) ? ST_ALLOC : ST_SEARCH;
					default: st_d = ST_DONE;
				endcase
			end
			ST_SEARCH: st_d = (idx_q >= bcnt_q) ? ST_DONE : ST_SEARCH_WAIT;
			ST_SEARCH_WAIT: st_d = (tr_data[31+CW:CW] == cmd_q.block_address) ?
				ST_FOUND : ST_SEARCH;
			ST_FOUND: st_d = (cmd_q.action == ACT_RESIZE && !cmd_q.size_zero) ?
				ST_RESIZE_CHK : ST_FREE;
			ST_RESIZE_CHK: begin
				if ({1'b0, cmd_q.request_size} <= old_len) st_d = ST_DONE;
				else if (ocnt >= (SW+1)'(STACK_DEPTH)) st_d = ST_DONE;
				else st_d = ST_ALLOC;
			end
			ST_ALLOC: begin
				if (cmd_q.size_zero || cmd_q.too_large) st_d = ST_DONE;
				else if (ncnt != '0) st_d = ST_POP_WAIT;
				else st_d = ST_CARVE;
			end
			ST_POP_WAIT: st_d = is_move ? ST_FREE : ST_DONE;
			ST_CARVE: begin
				if (bcnt_q >= (BW+1)'(MAX_BLOCKS)) st_d = ST_DONE;
				else if (end_w > {1'b0, limit_q}) st_d = ST_DONE;
				else st_d = is_move ? ST_FREE : ST_DONE;
			end
			ST_FREE: st_d = ST_DONE;
			ST_DONE: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_take = (st_q == ST_IDLE) && cmd_valid && !rsp_valid_q;
		tw_we = (st_q == ST_CARVE) && (bcnt_q < (BW+1)'(MAX_BLOCKS)) &&
			(end_w <= {1'b0, limit_q});
		sw_we = (st_q == ST_FREE) && (ocnt < (SW+1)'(STACK_DEPTH));
	end

	always_ff @(posedge clk) begin
		if (cmd_take) cmd_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			limit_q <= 32'hFFFF_FFFF;
			bump_q <= 32'd0;
			bcnt_q <= '0;
			for (int i = 0; i < SIZE_CLASSES; i++) scnt_q[i] <= '0;
			idx_q <= '0;
			oc_q <= '0;
			err_q <= ERR_OK;
			res_q <= 32'd0;
			copy_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_we && cfg_sel == CFG_HEAP_BASE) bump_q <= cfg_data;
			if (cfg_we && cfg_sel == CFG_HEAP_LIMIT) limit_q <= cfg_data;
			if (rsp_take && rsp_valid_q) rsp_valid_q <= 1'b0;
			case (st_q)
				ST_DISPATCH: begin
					idx_q <= '0;
					err_q <= ERR_OK;
					res_q <= 32'd0;
					copy_q <= 1'b0;
				end
				ST_SEARCH: begin
					if (idx_q >= bcnt_q) err_q <= ERR_UNKNOWN;
				end
				ST_SEARCH_WAIT: begin
					oc_q <= tr_data[CW-1:0];
					idx_q <= idx_q + 1'b1;
				end
				ST_RESIZE_CHK: begin
					if ({1'b0, cmd_q.request_size} <= old_len) res_q <= cmd_q.block_address;
					else if (ocnt >= (SW+1)'(STACK_DEPTH)) err_q <= ERR_FULL;
				end
				ST_ALLOC: begin
					if (cmd_q.too_large && !cmd_q.size_zero) err_q <= ERR_TOO_LARGE;
					else if (!cmd_q.size_zero && ncnt != '0) scnt_q[nc] <= ncnt - 1'b1;
				end
				ST_POP_WAIT: begin
					res_q <= sr_data;
					copy_q <= is_move;
				end
				ST_CARVE: begin
					if (bcnt_q >= (BW+1)'(MAX_BLOCKS)) err_q <= ERR_FULL;
					else if (end_w > {1'b0, limit_q}) err_q <= ERR_EXHAUSTED;
					else begin
						bump_q <= end_w[31:0];
						bcnt_q <= bcnt_q + 1'b1;
						res_q <= start_w[31:0];
						copy_q <= is_move;
					end
				end
				ST_FREE: begin
					if (ocnt >= (SW+1)'(STACK_DEPTH)) err_q <= ERR_FULL;
					else scnt_q[oc_q] <= ocnt + 1'b1;
				end
				ST_DONE: begin
					rsp_valid_q <= 1'b1;
					rsp_q.result_address <= res_q;
					rsp_q.is_null <= (res_q == 32'd0);
					rsp_q.error_code <= err_q;
					rsp_q.copy_needed <= copy_q;
					rsp_q.copy_source <= copy_q ? cmd_q.block_address : 32'd0;
					rsp_q.copy_length <= copy_q ? old_len[31:0] : 32'd0;
				end
				default: ;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
endmodule

// ===== src/power_of_two_class_allocator.sv =====
// Power-of-two size class heap allocator.
// Request words (allocate, free, resize) enter through a queue port: a word
// is taken on a rising edge with push high and full low. Result words leave
// through a queue port: the oldest result is shown while empty is low and is
// taken on a rising edge with pop high.
// The front classifies each word (size class, zero and oversize checks) into
// a two-deep queue; the back runs a sequencer over the block table RAM and
// the class stack RAM, one memory read per step.
// An allocate is served from its class stack or by a carve; a zero or
// oversize allocate is answered without either. Free and resize walk the
// block table, a search step and a read wait per entry searched, and a
// resize that moves its block allocates anew and then frees the old one.
// One request is worked at a time.
// The result register holds one word; while it is not popped the back stops
// and the front queue fills, then full rises.
// Reset clears the bump pointer to heap_base (zero), the heap limit to all
// ones, every class stack count and the block count. The RAM contents are
// not cleared, so there is no clearing pass. Configuration writes (cfg_we,
// cfg_index, cfg_data) are taken at once; writing heap_base reloads the
// bump pointer.
module power_of_two_class_allocator (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input potca_pkg::req_t req,
	output logic empty,
	input logic pop,
	output potca_pkg::rsp_t rsp,
	input logic cfg_we,
	input logic cfg_index,
	input logic [31:0] cfg_data
);
	import potca_pkg::*;

	cmd_t cmd;
	logic cmd_valid, cmd_take, rsp_valid;

	potca_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
	);

	potca_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_sel(cfg_index),
		.cfg_data(cfg_data), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
		.cmd(cmd), .rsp_valid(rsp_valid), .rsp_take(pop), .rsp(rsp)
	);

	assign empty = !rsp_valid;
endmodule

// ===== src/potca_checker.sv =====
module potca_checker (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input potca_pkg::rsp_t rsp
);
	import potca_pkg::*;

	a_null: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (rsp.is_null == (rsp.result_address == 32'd0)))
		else $error("is_null disagrees with address");
	a_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !rsp.copy_needed) |-> (rsp.copy_source == 0 && rsp.copy_length == 0))
		else $error("copy fields set without copy");
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.error_code != ERR_OK) |-> (rsp.is_null && !rsp.copy_needed))
		else $error("error result carries a block");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(rsp)))
		else $error("result dropped while stalled");
endmodule

bind power_of_two_class_allocator potca_checker u_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .rsp(rsp)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import potca_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_HEAP_BASE;
	logic [31:0] cfg_data = '0;
	req_t req = '0;
	logic full;
	logic empty;
	rsp_t rsp;

	power_of_two_class_allocator u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .rsp(rsp), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Shadow of the allocator's state, updated as each request word is accepted.
	logic [31:0] shd_limit, shd_bump;
	logic [31:0] shd_stack [SIZE_CLASSES * STACK_DEPTH];
	int unsigned shd_depth [SIZE_CLASSES];
	logic [31:0] shd_tab_addr [MAX_BLOCKS];
	logic [4:0] shd_tab_cls [MAX_BLOCKS];
	int unsigned shd_blocks;

	req_t pending_words[$];
	rsp_t awaited_rsp[$];
	int errors = 0;
	int accepted = 0;
	int popped = 0;
	bit hold_off = 1'b0;

	// Allocation: class from the rounded size, then the class stack, then a carve.
	function automatic logic [2:0] shd_alloc(input logic [31:0] size, output logic [31:0] a);
		int c;
		logic [32:0] start, stop;
		a = '0;
		if (size == 0) return ERR_OK;
		if (size > 32'h8000_0000) return ERR_TOO_LARGE;
		c = 0;
		while (c < 31 && (33'd1 << c) < {1'b0, size}) c++;
		if (c >= SIZE_CLASSES) return ERR_TOO_LARGE;
		if (shd_depth[c] > 0) begin
			shd_depth[c]--;
			a = shd_stack[c * STACK_DEPTH + shd_depth[c]];
			return ERR_OK;
		end
		if (shd_blocks >= MAX_BLOCKS) return ERR_FULL;
		start = {1'b0, shd_bump} + 33'd8 - {30'd0, shd_bump[2:0]};
		stop = start + (33'd1 << c);
		if (stop > {1'b0, shd_limit}) return ERR_EXHAUSTED;
		shd_bump = stop[31:0];
		shd_tab_addr[shd_blocks] = start[31:0];
		shd_tab_cls[shd_blocks] = 5'(c);
		shd_blocks++;
		a = start[31:0];
		return ERR_OK;
	endfunction

	function automatic int shd_lookup(input logic [31:0] a);
		for (int i = 0; i < shd_blocks; i++)
			if (shd_tab_addr[i] == a) return i;
		return -1;
	endfunction

	function automatic logic [2:0] shd_release(input logic [31:0] a);
		int s;
		int c;
		if (a == 0) return ERR_OK;
		s = shd_lookup(a);
		if (s < 0) return ERR_UNKNOWN;
		c = shd_tab_cls[s];
		if (shd_depth[c] >= STACK_DEPTH) return ERR_FULL;
		shd_stack[c * STACK_DEPTH + shd_depth[c]] = a;
		shd_depth[c]++;
		return ERR_OK;
	endfunction

	function automatic rsp_t predict_rsp(input req_t w);
		rsp_t r;
		logic [31:0] a;
		logic [32:0] old_len;
		int s;
		r = '0;
		a = '0;
		case (w.action)
			ACT_ALLOC: begin
				r.error_code = shd_alloc(w.request_size, a);
			end
			ACT_FREE: begin
				r.error_code = shd_release(w.block_address);
			end
			ACT_RESIZE: begin
				if (w.block_address == 0) begin
					r.error_code = shd_alloc(w.request_size, a);
				end else if (w.request_size == 0) begin
					r.error_code = shd_release(w.block_address);
				end else begin
					s = shd_lookup(w.block_address);
					if (s < 0) begin
						r.error_code = ERR_UNKNOWN;
					end else begin
						old_len = 33'd1 << shd_tab_cls[s];
						if ({1'b0, w.request_size} <= old_len) begin
							a = w.block_address;
						end else if (shd_depth[shd_tab_cls[s]] >= STACK_DEPTH) begin
							r.error_code = ERR_FULL;
						end else begin
							r.error_code = shd_alloc(w.request_size, a);
							if (r.error_code == ERR_OK) begin
								void'(shd_release(w.block_address));
								r.copy_needed = 1'b1;
								r.copy_source = w.block_address;
								r.copy_length = old_len[31:0];
							end else begin
								a = '0;
							end
						end
					end
				end
			end
			default: ;
		endcase
		r.result_address = a;
		r.is_null = (a == 0);
		return r;
	endfunction

	task automatic shd_clear();
		shd_limit = '1;
		shd_bump = '0;
		shd_blocks = 0;
		foreach (shd_depth[i]) shd_depth[i] = 0;
	endtask

	// Driver: bursts of random length with random gaps between them.
	// The word on req stays at the head of the queue until it is accepted.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				awaited_rsp.push_back(predict_rsp(req));
				accepted++;
				void'(pending_words.pop_front());
			end
			if (!(push && full)) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (pending_words.size() > 0) begin
					req <= pending_words[0];
					push <= 1'b1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 30);
					end else begin
						burst_left--;
						if (burst_left == 0) gap_left = $urandom_range(0, 6);
					end
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: the receiver stalls on its own pattern, or wholly during a hold-off.
	int stall_mode = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				popped++;
				if (awaited_rsp.size() == 0) begin
					$error("result word with nothing expected");
					errors++;
				end else begin
					rsp_t e;
					e = awaited_rsp.pop_front();
					if (rsp.result_address !== e.result_address) begin
						$error("result_address exp %h got %h", e.result_address, rsp.result_address);
						errors++;
					end
					if (rsp.is_null !== e.is_null) begin
						$error("is_null exp %b got %b", e.is_null, rsp.is_null);
						errors++;
					end
					if (rsp.error_code !== e.error_code) begin
						$error("error_code exp %0d got %0d", e.error_code, rsp.error_code);
						errors++;
					end
					if (rsp.copy_needed !== e.copy_needed) begin
						$error("copy_needed exp %b got %b", e.copy_needed, rsp.copy_needed);
						errors++;
					end
					if (rsp.copy_source !== e.copy_source) begin
						$error("copy_source exp %h got %h", e.copy_source, rsp.copy_source);
						errors++;
					end
					if (rsp.copy_length !== e.copy_length) begin
						$error("copy_length exp %h got %h", e.copy_length, rsp.copy_length);
						errors++;
					end
				end
			end
			if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
			if (hold_off) pop <= 1'b0;
			else if (stall_mode == 0) pop <= 1'b1;
			else if (stall_mode == 1) pop <= ($urandom_range(0, 3) != 0);
			else pop <= ($urandom_range(0, 3) == 0);
		end
	end

	task automatic wait_drained();
		while (pending_words.size() > 0 || push || awaited_rsp.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Configuration writes happen only with the block drained.
	task automatic write_reg(input logic idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_HEAP_BASE) begin
			shd_bump = val;
		end else begin
			shd_limit = val;
		end
	endtask

	function automatic req_t make_word(input logic [1:0] act, input logic [31:0] a,
	                                   input logic [31:0] sz);
		req_t w;
		w.action = act;
		w.block_address = a;
		w.request_size = sz;
		return w;
	endfunction

	// Mostly small sizes; free and resize mostly name blocks known to the table.
	function automatic req_t random_word();
		logic [1:0] act;
		logic [31:0] a, sz;
		int k;
		k = $urandom_range(0, 99);
		act = (k < 45) ? ACT_ALLOC : (k < 75) ? ACT_FREE : (k < 98) ? ACT_RESIZE : ACT_UNUSED;
		k = $urandom_range(0, 99);
		if (k < 80) sz = $urandom_range(1, 300);
		else if (k < 85) sz = 0;
		else if (k < 95) sz = 32'd1 << $urandom_range(0, 31);
		else sz = $urandom();
		k = $urandom_range(0, 99);
		if (k < 80 && shd_blocks > 0) a = shd_tab_addr[$urandom_range(0, shd_blocks - 1)];
		else if (k < 88) a = 0;
		else a = $urandom();
		return make_word(act, a, sz);
	endfunction

	initial begin
		int nphase;
		shd_clear();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero size, oversize, exact powers, free of zero, unknown
		// address, double free, resize paths and the unused action code.
		pending_words.push_back(make_word(ACT_ALLOC, 0, 0));
		pending_words.push_back(make_word(ACT_ALLOC, 0, 32'h8000_0001));
		pending_words.push_back(make_word(ACT_ALLOC, 0, 32'hFFFF_FFFF));
		pending_words.push_back(make_word(ACT_ALLOC, 0, 1));
		pending_words.push_back(make_word(ACT_ALLOC, 0, 16));
		pending_words.push_back(make_word(ACT_ALLOC, 0, 17));
		pending_words.push_back(make_word(ACT_FREE, 0, 0));
		pending_words.push_back(make_word(ACT_FREE, 32'hFFFF_FFFF, 5));
		pending_words.push_back(make_word(ACT_FREE, 32'd8, 0));
		pending_words.push_back(make_word(ACT_FREE, 32'd8, 0));
		pending_words.push_back(make_word(ACT_ALLOC, 0, 1));
		pending_words.push_back(make_word(ACT_ALLOC, 0, 1));
		pending_words.push_back(make_word(ACT_RESIZE, 0, 8));
		pending_words.push_back(make_word(ACT_RESIZE, 32'd16, 2));
		pending_words.push_back(make_word(ACT_RESIZE, 32'd16, 100));
		pending_words.push_back(make_word(ACT_RESIZE, 32'd16, 0));
		pending_words.push_back(make_word(ACT_RESIZE, 32'h1234_5678, 9));
		pending_words.push_back(make_word(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending_words.push_back(make_word(ACT_ALLOC, 0, 32'h8000_0000));
		wait_drained();

		// Long hold-off on the receiver while the sender keeps offering words.
		hold_off = 1'b1;
		repeat (30) pending_words.push_back(make_word(ACT_ALLOC, 0, 32));
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
		wait_drained();

		// Phases of random words under several heap settings, extremes among them.
		for (nphase = 0; nphase < 6; nphase++) begin
			case (nphase)
				0: begin write_reg(CFG_HEAP_BASE, 32'h0000_1000); write_reg(CFG_HEAP_LIMIT, 32'h0001_0000); end
				1: begin write_reg(CFG_HEAP_BASE, 32'hFFFF_FF00); write_reg(CFG_HEAP_LIMIT, 32'hFFFF_FFFF); end
				2: begin write_reg(CFG_HEAP_BASE, 32'h0000_0003); write_reg(CFG_HEAP_LIMIT, 32'h0000_0000); end
				3: begin write_reg(CFG_HEAP_BASE, 32'h5555_5555); write_reg(CFG_HEAP_LIMIT, 32'hAAAA_AAAA); end
				4: begin write_reg(CFG_HEAP_BASE, 32'h8000_0007); write_reg(CFG_HEAP_LIMIT, 32'hFFFF_FFFF); end
				default: begin write_reg(CFG_HEAP_BASE, 32'h0000_0000); write_reg(CFG_HEAP_LIMIT, 32'h7FFF_FFFF); end
			endcase
			// Words are drawn as they are queued so they can name live blocks.
			repeat (330) begin
				pending_words.push_back(random_word());
				while (pending_words.size() > 4) @(posedge clk);
			end
			wait_drained();
		end

		$display("Covered %0d request words and %0d result words over six heap settings,",
		         accepted, popped);
		$display("with table fills, stack fills, exhaustion and a long receiver hold-off.");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
src/potca_pkg.sv
src/potca_ram.sv
src/potca_front.sv
src/potca_back.sv
src/power_of_two_class_allocator.sv
src/potca_checker.sv
bench/tb_top.sv
